// ===== hdl/lbs_pkg.sv =====
// shared constants, operation codes and controller/datapath link types
package lbs_pkg;

  localparam int PaletteBones = 64;
  localparam int WordsPerBone = 12;
  localparam int PaletteDepth = PaletteBones * WordsPerBone;
  localparam int BoneW        = (PaletteBones > 1) ? $clog2(PaletteBones) : 1;
  localparam int AddrW        = (PaletteDepth > 1) ? $clog2(PaletteDepth) : 1;
  localparam int StepW        = 7;

  // datapath operations
  localparam logic [3:0] OP_NONE  = 4'd0;
  localparam logic [3:0] OP_MAT   = 4'd1;
  localparam logic [3:0] OP_WGT   = 4'd2;
  localparam logic [3:0] OP_DIVP  = 4'd3;
  localparam logic [3:0] OP_NSHFT = 4'd4;
  localparam logic [3:0] OP_SQ    = 4'd5;
  localparam logic [3:0] OP_SQRT  = 4'd6;
  localparam logic [3:0] OP_DIVN  = 4'd7;
  localparam logic [3:0] OP_OUT   = 4'd8;

  typedef struct packed {
    logic             capture;
    logic [3:0]       op;
    logic [StepW-1:0] step;
  } lbs_cmd_t;

  typedef struct packed {
    logic in_mode;
    logic in_last;
    logic in_bone_ok;
    logic last_q;
    logic wsum_big;
    logic shift_done;
    logic out_free;
  } lbs_stat_t;

endpackage

// ===== hdl/linear_blend_skinning_vertex_unit.sv =====
// palette writes and skipped influences are taken in the idle state; a used influence makes
// 12 palette reads through one memory port, then 6 weight multiplies on one multiplier
// vertex finish: pass-through goes straight to the output register; blended runs through
// the 64-step divider lanes (used twice), the normalize shift loop and a 32-step square root
// one item in flight at a time; the next item is taken while a result waits in the output register
// rst is synchronous, active high: clears control, accumulators and palette_count, not the palette
module linear_blend_skinning_vertex_unit import lbs_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [6:0]         cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               mode,
  input  logic [15:0]        bone_index,
  input  logic [3:0]         palette_element,
  input  logic signed [31:0] palette_value,
  input  logic [16:0]        weight,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] pos_z,
  input  logic signed [31:0] nrm_x,
  input  logic signed [31:0] nrm_y,
  input  logic signed [31:0] nrm_z,
  input  logic               last_influence,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_pos_x,
  output logic signed [31:0] out_pos_y,
  output logic signed [31:0] out_pos_z,
  output logic signed [31:0] out_nrm_x,
  output logic signed [31:0] out_nrm_y,
  output logic signed [31:0] out_nrm_z,
  output logic               skinned
);

  lbs_cmd_t  cmd;
  lbs_stat_t stat;

  lbs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  lbs_datapath u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data),
    .mode            (mode),
    .bone_index      (bone_index),
    .palette_element (palette_element),
    .palette_value   (palette_value),
    .weight          (weight),
    .pos_x           (pos_x),
    .pos_y           (pos_y),
    .pos_z           (pos_z),
    .nrm_x           (nrm_x),
    .nrm_y           (nrm_y),
    .nrm_z           (nrm_z),
    .last_influence  (last_influence),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_pos_x       (out_pos_x),
    .out_pos_y       (out_pos_y),
    .out_pos_z       (out_pos_z),
    .out_nrm_x       (out_nrm_x),
    .out_nrm_y       (out_nrm_y),
    .out_nrm_z       (out_nrm_z),
    .skinned         (skinned)
  );

endmodule

// ===== hdl/lbs_ctrl.sv =====
// sequencer for palette writes, influence accumulation and vertex finish
module lbs_ctrl import lbs_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  lbs_stat_t stat,
  output lbs_cmd_t  cmd
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MAT  = 4'd1;
  localparam logic [3:0] S_WGT  = 4'd2;
  localparam logic [3:0] S_FIN  = 4'd3;
  localparam logic [3:0] S_DIVP = 4'd4;
  localparam logic [3:0] S_NSH  = 4'd5;
  localparam logic [3:0] S_SQ   = 4'd6;
  localparam logic [3:0] S_SQRT = 4'd7;
  localparam logic [3:0] S_DIVN = 4'd8;
  localparam logic [3:0] S_OUT  = 4'd9;

  logic [3:0]       state, state_next;
  logic [StepW-1:0] step, step_next;
  logic             accept;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_next  = state;
    step_next   = step + 1'b1;
    cmd.capture = accept;
    cmd.step    = step;
    cmd.op      = OP_NONE;
    unique case (state)
      S_IDLE: begin
        step_next = '0;
        if (accept && stat.in_mode) begin
          if (stat.in_bone_ok) state_next = S_MAT;
          else if (stat.in_last) state_next = S_FIN;
        end
      end
      S_MAT: begin
        cmd.op = OP_MAT;
        if (step == 7'd13) begin
          state_next = S_WGT;
          step_next  = '0;
        end
      end
      S_WGT: begin
        cmd.op = OP_WGT;
        if (step == 7'd6) begin
          state_next = stat.last_q ? S_FIN : S_IDLE;
          step_next  = '0;
        end
      end
      S_FIN: begin
        step_next  = '0;
        state_next = stat.wsum_big ? S_DIVP : S_OUT;
      end
      S_DIVP: begin
        cmd.op = OP_DIVP;
        if (step == 7'd64) begin
          state_next = S_NSH;
          step_next  = '0;
        end
      end
      S_NSH: begin
        cmd.op = OP_NSHFT;
        // the largest magnitude sits in [2^30, 2^31) or all are zero
        if (step != '0 && stat.shift_done) begin
          state_next = S_SQ;
          step_next  = '0;
        end
      end
      S_SQ: begin
        cmd.op = OP_SQ;
        if (step == 7'd3) begin
          state_next = S_SQRT;
          step_next  = '0;
        end
      end
      S_SQRT: begin
        cmd.op = OP_SQRT;
        if (step == 7'd32) begin
          state_next = S_DIVN;
          step_next  = '0;
        end
      end
      S_DIVN: begin
        cmd.op = OP_DIVN;
        if (step == 7'd64) begin
          state_next = S_OUT;
          step_next  = '0;
        end
      end
      S_OUT: begin
        cmd.op    = OP_OUT;
        step_next = '0;
        if (stat.out_free) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
        step_next  = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

endmodule

// ===== hdl/lbs_datapath.sv =====
// palette store, transform/accumulate pipeline, divider lanes, normalizer, output register
module lbs_datapath import lbs_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  lbs_cmd_t           cmd,
  output lbs_stat_t          stat,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [6:0]         cfg_data,
  input  logic               mode,
  input  logic [15:0]        bone_index,
  input  logic [3:0]         palette_element,
  input  logic signed [31:0] palette_value,
  input  logic [16:0]        weight,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] pos_z,
  input  logic signed [31:0] nrm_x,
  input  logic signed [31:0] nrm_y,
  input  logic signed [31:0] nrm_z,
  input  logic               last_influence,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_pos_x,
  output logic signed [31:0] out_pos_y,
  output logic signed [31:0] out_pos_z,
  output logic signed [31:0] out_nrm_x,
  output logic signed [31:0] out_nrm_y,
  output logic signed [31:0] out_nrm_z,
  output logic               skinned
);

  localparam int CsW = 50;

  function automatic logic [1:0] k_row(logic [3:0] k);
    if (k < 4'd3) return 2'd0;
    else if (k < 4'd6) return 2'd1;
    else if (k < 4'd9) return 2'd2;
    else return 2'd3;
  endfunction

  function automatic logic signed [31:0] sat32(logic signed [CsW-1:0] x);
    if (x[CsW-1:31] == '0 || x[CsW-1:31] == '1) return x[31:0];
    else return x[CsW-1] ? 32'sh8000_0000 : 32'sh7fff_ffff;
  endfunction

  function automatic logic signed [63:0] sat_add64(logic signed [63:0] a,
                                                   logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    else return s[63:0];
  endfunction

  function automatic logic [63:0] mag64(logic signed [63:0] x);
    return x[63] ? 64'(-x) : 64'(x);
  endfunction

  // configuration
  logic [6:0] palette_count;
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) palette_count <= '0;
    else if (cfg_valid) palette_count <= cfg_data;
  end

  // captured item
  logic signed [31:0] pos_q [3];
  logic signed [31:0] nrm_q [3];
  logic [16:0]        w_q;
  logic [BoneW-1:0]   bone_q;
  logic               last_q;
  logic [16:0]        w_sat;

  assign w_sat = (weight > 17'd65536) ? 17'd65536 : weight;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_q <= 1'b0;
    end else if (cmd.capture && mode) begin
      last_q <= last_influence;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture && mode) begin
      pos_q[0] <= pos_x;
      pos_q[1] <= pos_y;
      pos_q[2] <= pos_z;
      nrm_q[0] <= nrm_x;
      nrm_q[1] <= nrm_y;
      nrm_q[2] <= nrm_z;
      w_q      <= w_sat;
      bone_q   <= bone_index[BoneW-1:0];
    end
  end

  // palette store
  logic [31:0]      palette [PaletteDepth];
  logic [31:0]      rdata;
  logic             we;
  logic [AddrW-1:0] waddr, raddr;

  assign we    = cmd.capture && !mode && (bone_index < 16'(PaletteBones)) &&
                 (palette_element < 4'(WordsPerBone));
  assign waddr = AddrW'(AddrW'(bone_index[BoneW-1:0]) * AddrW'(WordsPerBone)) +
                 AddrW'(palette_element);
  assign raddr = AddrW'(AddrW'(bone_q) * AddrW'(WordsPerBone)) + AddrW'(cmd.step[3:0]);

  always_ff @(posedge clk) begin
    if (we) palette[waddr] <= palette_value;
    rdata <= palette[raddr];
  end

  // matrix pipeline: read, multiply, column sum
  logic                  mv1, mv2;
  logic [3:0]            mk1, mk2;
  logic [1:0]            r1, r2, rsel;
  logic [3:0]            c2;
  logic signed [63:0]    p_pos, p_nrm;
  logic signed [31:0]    tr;
  logic signed [CsW-1:0] cs_pos [3];
  logic signed [CsW-1:0] cs_nrm [3];

  assign r1   = k_row(mk1);
  assign rsel = (r1 == 2'd3) ? 2'd0 : r1;
  assign r2   = k_row(mk2);
  assign c2   = 4'(mk2 - 4'(4'(r2) * 4'd3));

  always_ff @(posedge clk) begin
    if (rst) begin
      mv1 <= 1'b0;
      mv2 <= 1'b0;
    end else begin
      mv1 <= (cmd.op == OP_MAT) && (cmd.step < 7'd12);
      mv2 <= mv1;
    end
  end

  always_ff @(posedge clk) begin
    mk1   <= cmd.step[3:0];
    mk2   <= mk1;
    p_pos <= pos_q[rsel] * $signed(rdata);
    p_nrm <= nrm_q[rsel] * $signed(rdata);
    tr    <= rdata;
    if (cmd.capture) begin
      for (int i = 0; i < 3; i++) begin
        cs_pos[i] <= '0;
        cs_nrm[i] <= '0;
      end
    end else if (mv2) begin
      if (r2 == 2'd3) begin
        cs_pos[c2[1:0]] <= cs_pos[c2[1:0]] + CsW'(tr);
      end else begin
        cs_pos[c2[1:0]] <= cs_pos[c2[1:0]] + CsW'(p_pos >>> 16);
        cs_nrm[c2[1:0]] <= cs_nrm[c2[1:0]] + CsW'(p_nrm >>> 16);
      end
    end
  end

  // weighting into the accumulators
  logic               wv1;
  logic [2:0]         wj1;
  logic signed [31:0] wsel;
  logic signed [49:0] wprod;
  logic signed [63:0] acc [6];
  logic [23:0]        wsum;
  logic [24:0]        wsum_add;
  logic               out_load;

  always_comb begin
    case (cmd.step[2:0])
      3'd0: wsel = sat32(cs_pos[0]);
      3'd1: wsel = sat32(cs_pos[1]);
      3'd2: wsel = sat32(cs_pos[2]);
      3'd3: wsel = sat32(cs_nrm[0]);
      3'd4: wsel = sat32(cs_nrm[1]);
      3'd5: wsel = sat32(cs_nrm[2]);
      default: wsel = '0;
    endcase
  end

  assign wsum_add = 25'(wsum) + 25'(w_q);
  assign out_load = (cmd.op == OP_OUT) && stat.out_free;

  always_ff @(posedge clk) begin
    wj1   <= cmd.step[2:0];
    wprod <= wsel * $signed({1'b0, w_q});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wv1  <= 1'b0;
      wsum <= '0;
      for (int i = 0; i < 6; i++) acc[i] <= '0;
    end else begin
      wv1 <= (cmd.op == OP_WGT) && (cmd.step < 7'd6);
      if (out_load) begin
        wsum <= '0;
        for (int i = 0; i < 6; i++) acc[i] <= '0;
      end else if (wv1) begin
        acc[wj1] <= sat_add64(acc[wj1], 64'(wprod));
        if (wj1 == 3'd0) wsum <= wsum_add[24] ? '1 : wsum_add[23:0];
      end
    end
  end

  // three restoring divider lanes, shared by position divide and normal scale
  logic [63:0] dq   [3];
  logic [31:0] drem [3];
  logic [31:0] dd;
  logic [32:0] rem2 [3];
  logic        div_op;

  assign div_op = (cmd.op == OP_DIVP) || (cmd.op == OP_DIVN);

  always_comb begin
    for (int i = 0; i < 3; i++) rem2[i] = {drem[i], dq[i][63]};
  end

  // normalizer state
  logic [63:0] nm [3];
  logic [63:0] orv;
  logic [1:0]  sq_idx;
  logic        sqv1;
  logic [61:0] sqp;
  logic [63:0] sq;
  logic [63:0] sv, sr, sb, st;
  logic signed [31:0] res_pos [3];

  always_ff @(posedge clk) begin
    if (div_op && cmd.step == '0) begin
      for (int i = 0; i < 3; i++) begin
        drem[i] <= '0;
        dq[i]   <= (cmd.op == OP_DIVP) ? mag64(acc[i]) : {nm[i][47:0], 16'd0};
      end
      dd <= (cmd.op == OP_DIVP) ? {8'd0, wsum} : ((sr == '0) ? 32'd1 : sr[31:0]);
    end else if (div_op) begin
      for (int i = 0; i < 3; i++) begin
        if (rem2[i] >= {1'b0, dd}) begin
          drem[i] <= 32'(rem2[i] - {1'b0, dd});
          dq[i]   <= {dq[i][62:0], 1'b1};
        end else begin
          drem[i] <= rem2[i][31:0];
          dq[i]   <= {dq[i][62:0], 1'b0};
        end
      end
    end
  end

  assign orv             = nm[0] | nm[1] | nm[2];
  assign stat.shift_done = (orv[63:31] == '0) && (orv[30] || orv == '0);

  always_ff @(posedge clk) begin
    if (cmd.op == OP_NSHFT) begin
      if (cmd.step == '0) begin
        for (int i = 0; i < 3; i++) begin
          nm[i] <= mag64(acc[3 + i]);
          // quotient of the position divide, saturated with its sign
          if (acc[i][63]) begin
            res_pos[i] <= (dq[i] > 64'h8000_0000) ? 32'sh8000_0000 : -$signed(dq[i][31:0]);
          end else begin
            res_pos[i] <= (dq[i] > 64'h7fff_ffff) ? 32'sh7fff_ffff : $signed(dq[i][31:0]);
          end
        end
      end else if (orv[63:31] != '0) begin
        for (int i = 0; i < 3; i++) nm[i] <= nm[i] >> 1;
      end else if (orv != '0 && !orv[30]) begin
        for (int i = 0; i < 3; i++) nm[i] <= nm[i] << 1;
      end
    end
  end

  // sum of squares
  assign sq_idx = (cmd.step[1:0] == 2'd3) ? 2'd0 : cmd.step[1:0];

  always_ff @(posedge clk) begin
    sqp <= nm[sq_idx][30:0] * nm[sq_idx][30:0];
    if (rst) sqv1 <= 1'b0;
    else sqv1 <= (cmd.op == OP_SQ) && (cmd.step < 7'd3);
  end

  always_ff @(posedge clk) begin
    if (sqv1) sq <= sq + 64'(sqp);
    else if (cmd.op == OP_SQ && cmd.step == '0) sq <= '0;
  end

  // integer square root, two bits of the radicand per step
  assign st = sr + sb;

  always_ff @(posedge clk) begin
    if (cmd.op == OP_SQRT) begin
      if (cmd.step == '0) begin
        sv <= sq;
        sr <= '0;
        sb <= 64'h4000_0000_0000_0000;
      end else begin
        if (sv >= st) begin
          sv <= sv - st;
          sr <= (sr >> 1) + sb;
        end else begin
          sr <= sr >> 1;
        end
        sb <= sb >> 2;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (out_load) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (stat.wsum_big) begin
        out_pos_x <= res_pos[0];
        out_pos_y <= res_pos[1];
        out_pos_z <= res_pos[2];
        out_nrm_x <= acc[3][63] ? -$signed(dq[0][31:0]) : $signed(dq[0][31:0]);
        out_nrm_y <= acc[4][63] ? -$signed(dq[1][31:0]) : $signed(dq[1][31:0]);
        out_nrm_z <= acc[5][63] ? -$signed(dq[2][31:0]) : $signed(dq[2][31:0]);
        skinned   <= 1'b1;
      end else begin
        out_pos_x <= pos_q[0];
        out_pos_y <= pos_q[1];
        out_pos_z <= pos_q[2];
        out_nrm_x <= nrm_q[0];
        out_nrm_y <= nrm_q[1];
        out_nrm_z <= nrm_q[2];
        skinned   <= 1'b0;
      end
    end
  end

  assign stat.in_mode    = mode;
  assign stat.in_last    = last_influence;
  assign stat.in_bone_ok = (bone_index < {9'd0, palette_count}) &&
                           (bone_index < 16'(PaletteBones));
  assign stat.last_q     = last_q;
  assign stat.wsum_big   = (wsum > 24'd6);
  assign stat.out_free   = !out_valid || out_ready;

endmodule
